>>> rtl/core/nlep_pkg.sv
// Shared types and constants for the numeric line entry parser.
// No dependencies; every other file imports this package.
package nlep_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_BS = 8'h08;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [3:0] HEX_TEN = 4'hA;

  // Reciprocal of ten: floor(x / 10) == (x * DIV10_MAGIC) >> DIV10_SHIFT for 32-bit x.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  localparam logic RADIX_DEC = 1'b0;
  localparam logic RADIX_HEX = 1'b1;

  localparam logic KIND_ECHO   = 1'b0;
  localparam logic KIND_NUMBER = 1'b1;

  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_BKSP,
    OP_CR
  } op_t;

  // One classified word passed from the front end to the back end.
  typedef struct packed {
    op_t        op;
    logic       hex;
    logic [3:0] digit;
    logic [7:0] ch;
  } entry_t;

endpackage

>>> rtl/core/nlep_front.sv
// Front end: accepts received characters and classifies them.
// Depends on nlep_pkg; feeds nlep_queue.
module nlep_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_char,
  input  logic            radix_mode,
  input  logic            q_full,
  output logic            push,
  output nlep_pkg::entry_t push_entry
);
  import nlep_pkg::*;

  logic       is_dec;
  logic       is_upper;
  logic       is_lower;
  logic       is_digit;
  logic       is_bs;
  logic       is_cr;
  logic [3:0] digit_val;

  always_comb begin
    is_dec   = (in_rx_char >= CHAR_0) && (in_rx_char <= CHAR_9);
    is_upper = (radix_mode == RADIX_HEX) && (in_rx_char >= CHAR_UA) && (in_rx_char <= CHAR_UF);
    is_lower = (radix_mode == RADIX_HEX) && (in_rx_char >= CHAR_LA) && (in_rx_char <= CHAR_LF);
    is_digit = is_dec || is_upper || is_lower;
    is_bs    = (in_rx_char == CHAR_BS);
    is_cr    = (in_rx_char == CHAR_CR);

    priority if (is_upper) begin
      digit_val = 4'(in_rx_char - CHAR_UA) + HEX_TEN;
    end else if (is_lower) begin
      digit_val = 4'(in_rx_char - CHAR_LA) + HEX_TEN;
    end else begin
      digit_val = 4'(in_rx_char - CHAR_0);
    end

    push_entry.hex   = radix_mode;
    push_entry.digit = digit_val;
    push_entry.ch    = in_rx_char;
    priority if (is_cr) begin
      push_entry.op = OP_CR;
    end else if (is_digit) begin
      push_entry.op = OP_DIGIT;
    end else begin
      push_entry.op = OP_BKSP;
    end
  end

  // Characters that can never cause a result are dropped here.
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full && (is_cr || is_digit || is_bs);

endmodule

>>> rtl/core/nlep_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on nlep_pkg for the entry type.
module nlep_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  nlep_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output nlep_pkg::entry_t head_entry
);
  import nlep_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> rtl/core/nlep_back.sv
// Back end: updates accumulator and digit count, holds the result register.
// Depends on nlep_pkg; drains nlep_queue.
module nlep_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  nlep_pkg::entry_t head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_result_kind,
  output logic [7:0]       out_echo_char,
  output logic [31:0]      out_number_value
);
  import nlep_pkg::*;

  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [31:0] count_r;
  logic [31:0] count_nxt;
  logic        ovalid_r;
  logic        ovalid_nxt;
  logic        kind_r;
  logic        kind_nxt;
  logic [7:0]  echo_r;
  logic [7:0]  echo_nxt;
  logic [31:0] value_r;
  logic [31:0] value_nxt;

  logic [63:0] prod10;
  logic [31:0] quot10;
  logic [31:0] mul_radix;
  logic [31:0] div_radix;
  logic        slot_free;

  assign prod10 = {32'd0, acc_r} * {32'd0, DIV10_MAGIC};
  assign quot10 = 32'(prod10[63:DIV10_SHIFT]);

  assign slot_free = !ovalid_r || out_ready;
  assign pop       = head_valid && slot_free;

  always_comb begin
    if (head_entry.hex == RADIX_HEX) begin
      mul_radix = {acc_r[27:0], 4'd0};
      div_radix = {4'd0, acc_r[31:4]};
    end else begin
      mul_radix = {acc_r[28:0], 3'd0} + {acc_r[30:0], 1'b0};
      div_radix = quot10;
    end

    acc_nxt    = acc_r;
    count_nxt  = count_r;
    ovalid_nxt = ovalid_r && !out_ready;
    kind_nxt   = kind_r;
    echo_nxt   = echo_r;
    value_nxt  = value_r;

    if (pop) begin
      unique case (head_entry.op)
        OP_DIGIT: begin
          acc_nxt    = mul_radix + 32'(head_entry.digit);
          count_nxt  = count_r + 32'd1;
          ovalid_nxt = 1'b1;
          kind_nxt   = KIND_ECHO;
          echo_nxt   = head_entry.ch;
          value_nxt  = 32'd0;
        end
        OP_BKSP: begin
          // A backspace on an empty entry is swallowed without a result.
          if (count_r != 32'd0) begin
            acc_nxt    = div_radix;
            count_nxt  = count_r - 32'd1;
            ovalid_nxt = 1'b1;
            kind_nxt   = KIND_ECHO;
            echo_nxt   = head_entry.ch;
            value_nxt  = 32'd0;
          end
        end
        OP_CR: begin
          acc_nxt    = 32'd0;
          count_nxt  = 32'd0;
          ovalid_nxt = 1'b1;
          kind_nxt   = KIND_NUMBER;
          echo_nxt   = 8'd0;
          value_nxt  = acc_r;
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= 32'd0;
      count_r  <= 32'd0;
      ovalid_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    kind_r  <= kind_nxt;
    echo_r  <= echo_nxt;
    value_r <= value_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_result_kind  = kind_r;
  assign out_echo_char    = echo_r;
  assign out_number_value = value_r;

endmodule

>>> rtl/core/numeric_line_entry_parser.sv
// Top level of the numeric line entry parser: radix register and the three parts.
// Depends on nlep_pkg, nlep_front, nlep_queue and nlep_back.
//
//   Channel  Ports                                              Direction
//   in       in_valid, in_ready, in_rx_char                     received characters
//   out      out_valid, out_ready, out_result_kind,
//            out_echo_char, out_number_value                    echoes and numbers
//   cfg      cfg_wr_en, cfg_wr_data                             radix_mode register
//
// One character is taken per cycle while the queue has room; a result appears
// in the cycle after the back end pops its word from the two-entry queue.
// The back end retires one word per cycle while its result slot is free; its
// accumulator update holds the 32x32 reciprocal multiply for a decimal backspace.
// Reset clears the radix register, accumulator, digit count, queue and result valid.
// An output stall fills the queue; in_ready drops only when both entries are held.
module numeric_line_entry_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_echo_char,
  output logic [31:0] out_number_value,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import nlep_pkg::*;

  logic   radix_r;
  logic   radix_nxt;
  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head_entry;

  assign radix_nxt = cfg_wr_en ? cfg_wr_data : radix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_DEC;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  nlep_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_char (in_rx_char),
    .radix_mode (radix_r),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  nlep_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  nlep_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_entry       (head_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_echo_char    (out_echo_char),
    .out_number_value (out_number_value)
  );

endmodule
